// File: hdl/jac_pkg.sv
package jac_pkg;

    localparam int DZ_W    = 11;
    localparam int THR_W   = 8;
    localparam int POS_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [DZ_W-1:0]  DZ_RESET  = 11'd82;
    localparam logic [THR_W-1:0] THR_RESET = 8'd3;

    // Full-scale percent and the clamp bound.
    localparam int POS_SCALE = 100;
    localparam logic signed [POS_W-1:0] POS_MAX = 8'sd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE = 1'b0,
        CFG_THRESHOLD = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } t_pos_pair;

endpackage

// File: hdl/jac_axis.sv
module jac_axis #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0]          i_raw,
    input  logic [jac_pkg::DZ_W-1:0]        i_dead_zone,
    output logic signed [jac_pkg::POS_W-1:0] o_pos
);

    localparam int B      = SAMPLE_BITS;
    localparam int PROD_W = B + 7;
    localparam int CMP_W  = (B > jac_pkg::DZ_W) ? B : jac_pkg::DZ_W;
    localparam logic [B-1:0] MID = B'(1) << (B - 1);
    // Positive side divisor is 2^(B-1)-1.
    localparam logic [B:0]   DIV_POS = (B+1)'((1 << (B - 1)) - 1);

    logic                      negative;
    logic [B-1:0]              mag;
    logic                      in_dead;
    logic [PROD_W-1:0]         prod;
    logic [jac_pkg::POS_W-1:0] q0;
    logic [B:0]                rem;
    logic [jac_pkg::POS_W-1:0] q_pos;
    logic [jac_pkg::POS_W-1:0] q_sel;
    logic [jac_pkg::POS_W-1:0] q_clamp;

    always_comb begin
        negative = (i_raw < MID);
        mag      = negative ? (MID - i_raw) : (i_raw - MID);
        in_dead  = (CMP_W'(mag) < CMP_W'(i_dead_zone));
        prod     = PROD_W'(mag) * PROD_W'(jac_pkg::POS_SCALE);
        // Quotient by 2^(B-1); the remainder against 2^(B-1)-1 exceeds
        // the divisor at most once, so one correction step is exact.
        q0       = prod[PROD_W-1:B-1];
        rem      = (B+1)'(prod[B-2:0]) + (B+1)'(q0);
        q_pos    = (rem >= DIV_POS) ? (q0 + 1'b1) : q0;
        q_sel    = negative ? q0 : q_pos;
        q_clamp  = (q_sel > jac_pkg::POS_MAX) ? jac_pkg::POS_MAX : q_sel;
        if (in_dead) begin
            o_pos = '0;
        end else if (negative) begin
            o_pos = -$signed(q_clamp);
        end else begin
            o_pos = $signed(q_clamp);
        end
    end

endmodule

// File: hdl/jac_track.sv
module jac_track (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  jac_pkg::t_pos_pair        i_pos,
    input  logic [jac_pkg::THR_W-1:0] i_threshold,
    output logic                      o_changed
);

    localparam int DW = jac_pkg::POS_W + 1;

    jac_pkg::t_pos_pair r_last;
    jac_pkg::t_pos_pair n_last;

    logic signed [DW-1:0] diff_x;
    logic signed [DW-1:0] diff_y;
    logic [DW-1:0]        abs_x;
    logic [DW-1:0]        abs_y;

    always_comb begin
        diff_x = DW'(i_pos.pos_x) - DW'(r_last.pos_x);
        diff_y = DW'(i_pos.pos_y) - DW'(r_last.pos_y);
        abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
        o_changed = (abs_x > DW'(i_threshold)) || (abs_y > DW'(i_threshold));
        n_last = (i_step && o_changed) ? i_pos : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else begin
            r_last <= n_last;
        end
    end

endmodule

// File: hdl/joystick_axis_conditioner_unit.sv
// Channel   Direction  Word contents
// s_axis    in         tdata: raw_x, raw_y (SAMPLE_BITS each), zero pad to bytes
// m_axis    out        tdata: pos_x, pos_y (8 bit signed each); tuser: changed
// cfg       in         index 0 dead_zone (11 bit), index 1 threshold (8 bit)
//
// One word per cycle sustained while the output is not stalled; each word is
// held in the input register and moves to the output register when it is free.
// The compare against the last reported position sits between the two
// registers, so consecutive words see each other's updates in order.
// Synchronous active-low reset clears valids and last position and loads the dead-zone and threshold defaults.
// A stalled output holds its word while the input register keeps one more.
module joystick_axis_conditioner_unit #(
    parameter int SAMPLE_BITS = 12,
    localparam int S_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [S_TDATA_W-1:0]            i_s_tdata,   // raw_x, raw_y, pad
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [2*jac_pkg::POS_W-1:0]     o_m_tdata,   // pos_x, pos_y
    output logic                            o_m_tuser,   // changed
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jac_pkg::DZ_W-1:0]        i_cfg_data
);

    localparam int B = SAMPLE_BITS;

    logic                        r_in_valid;
    logic [B-1:0]                r_raw_x;
    logic [B-1:0]                r_raw_y;
    logic                        r_out_valid;
    jac_pkg::t_pos_pair          r_out_pos;
    logic                        r_out_changed;
    logic [jac_pkg::DZ_W-1:0]    r_dead_zone;
    logic [jac_pkg::THR_W-1:0]   r_threshold;

    logic                        out_free;
    logic                        step;
    logic                        s_accept;
    logic                        changed;
    jac_pkg::t_pos_pair          pos;

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    jac_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
        .i_raw       (r_raw_x),
        .i_dead_zone (r_dead_zone),
        .o_pos       (pos.pos_x)
    );

    jac_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
        .i_raw       (r_raw_y),
        .i_dead_zone (r_dead_zone),
        .o_pos       (pos.pos_y)
    );

    jac_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pos       (pos),
        .i_threshold (r_threshold),
        .o_changed   (changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dead_zone <= jac_pkg::DZ_RESET;
            r_threshold <= jac_pkg::THR_RESET;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (jac_pkg::t_cfg_idx'(i_cfg_index))
                    jac_pkg::CFG_DEAD_ZONE: begin
                        r_dead_zone <= i_cfg_data;
                    end
                    jac_pkg::CFG_THRESHOLD: begin
                        r_threshold <= i_cfg_data[jac_pkg::THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_raw_x <= i_s_tdata[B-1:0];
            r_raw_y <= i_s_tdata[2*B-1:B];
        end
        if (step) begin
            r_out_pos     <= pos;
            r_out_changed <= changed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_pos.pos_y, r_out_pos.pos_x};
    assign o_m_tuser  = r_out_changed;

endmodule
